/* rtl/blml_pkg.sv */
`timescale 1ns / 1ps

package blml_pkg;

    localparam int BIN_W     = 6;
    localparam int ENT_W     = 10;
    localparam int TAG_W     = 16;
    localparam int CNT_W     = 11;
    localparam int BIN_DEPTH = 64;
    localparam int ENT_DEPTH = 1024;

    typedef enum logic [2:0] {
        KIND_MOVE   = 3'd0,
        KIND_REMOVE = 3'd1,
        KIND_BINQ   = 3'd2,
        KIND_ENTQ   = 3'd3,
        KIND_CLEAR  = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_NOTHING  = 2'd1,
        ST_MISMATCH = 2'd2,
        ST_RANGE    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        FSM_CLR,
        FSM_IDLE,
        FSM_B,
        FSM_C,
        FSM_D,
        FSM_FIN
    } fsm_t;

    typedef struct packed {
        logic             vld;
        logic [ENT_W-1:0] idx;
    } link_t;

    typedef struct packed {
        logic             vld;
        logic [BIN_W-1:0] bin;
        logic [TAG_W-1:0] tag;
    } meta_t;

    typedef struct packed {
        link_t            head;
        logic [CNT_W-1:0] cnt;
    } bin_ent_t;

    typedef struct packed {
        logic             we;
        logic [ENT_W-1:0] waddr;
        meta_t            wdata;
        logic [ENT_W-1:0] raddr;
    } meta_req_t;

    typedef struct packed {
        logic             we;
        logic [ENT_W-1:0] waddr;
        link_t            wdata;
        logic [ENT_W-1:0] raddr;
    } link_req_t;

    typedef struct packed {
        logic             we;
        logic [BIN_W-1:0] waddr;
        bin_ent_t         wdata;
        logic [BIN_W-1:0] raddr;
    } bin_req_t;

    typedef struct packed {
        status_t          status;
        logic             found;
        logic [BIN_W-1:0] bin_out;
        logic [CNT_W-1:0] count;
        logic             link_valid;
        logic [ENT_W-1:0] link_index;
        logic [TAG_W-1:0] link_version;
    } res_t;

endpackage

/* rtl/blml_ram.sv */
`timescale 1ns / 1ps

module blml_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/blml_ctrl.sv */
`timescale 1ns / 1ps

module blml_ctrl
    import blml_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [31:0] s_tdata,
    input  logic [2:0] s_tuser,
    output logic       out_valid,
    input  logic       out_ready,
    output res_t       out_res,
    output meta_req_t  meta_req,
    input  meta_t      meta_rd,
    output link_req_t  prev_req,
    input  link_t      prev_rd,
    output link_req_t  next_req,
    input  link_t      next_rd,
    output bin_req_t   bin_req,
    input  bin_ent_t   bin_rd
);

    fsm_t             state_reg, state_next;
    logic [2:0]       kind_reg, kind_next;
    logic [BIN_W-1:0] bin_reg, bin_next;
    logic [ENT_W-1:0] ent_reg, ent_next;
    logic [TAG_W-1:0] ver_reg, ver_next;
    meta_t            meta_reg, meta_next;
    link_t            nxt_reg, nxt_next;
    link_t            hd_reg, hd_next;
    logic             upd_reg, upd_next;
    logic             clrop_reg, clrop_next;
    logic [ENT_W-1:0] cnt_reg, cnt_next;
    res_t             res_reg, res_next;
    logic             ov_reg, ov_next;
    res_t             out_reg, out_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_CLR;
            clrop_reg <= 1'b0;
            cnt_reg   <= '0;
            upd_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clrop_reg <= clrop_next;
            cnt_reg   <= cnt_next;
            upd_reg   <= upd_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        bin_reg  <= bin_next;
        ent_reg  <= ent_next;
        ver_reg  <= ver_next;
        meta_reg <= meta_next;
        nxt_reg  <= nxt_next;
        hd_reg   <= hd_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        bin_next   = bin_reg;
        ent_next   = ent_reg;
        ver_next   = ver_reg;
        meta_next  = meta_reg;
        nxt_next   = nxt_reg;
        hd_next    = hd_reg;
        upd_next   = upd_reg;
        clrop_next = clrop_reg;
        cnt_next   = cnt_reg;
        res_next   = res_reg;
        ov_next    = ov_reg;
        out_next   = out_reg;
        s_tready   = 1'b0;
        meta_req   = '0;
        prev_req   = '0;
        next_req   = '0;
        bin_req    = '0;

        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            FSM_CLR:
            begin
                // sweep every entity slot, and the bin table on the low slots
                meta_req.we    = 1'b1;
                meta_req.waddr = cnt_reg;
                prev_req.we    = 1'b1;
                prev_req.waddr = cnt_reg;
                next_req.we    = 1'b1;
                next_req.waddr = cnt_reg;
                bin_req.we     = (cnt_reg >> BIN_W) == '0;
                bin_req.waddr  = cnt_reg[BIN_W-1:0];
                cnt_next       = cnt_reg + 1'b1;
                if (cnt_reg == ENT_W'(ENT_DEPTH - 1))
                begin
                    state_next = clrop_reg ? FSM_FIN : FSM_IDLE;
                end
            end
            FSM_IDLE:
            begin
                s_tready       = 1'b1;
                meta_req.raddr = s_tdata[BIN_W +: ENT_W];
                prev_req.raddr = s_tdata[BIN_W +: ENT_W];
                next_req.raddr = s_tdata[BIN_W +: ENT_W];
                bin_req.raddr  = s_tdata[BIN_W-1:0];
                if (s_tvalid)
                begin
                    kind_next  = s_tuser;
                    bin_next   = s_tdata[BIN_W-1:0];
                    ent_next   = s_tdata[BIN_W +: ENT_W];
                    ver_next   = s_tdata[BIN_W+ENT_W +: TAG_W];
                    res_next   = '0;
                    upd_next   = 1'b0;
                    clrop_next = 1'b1;
                    cnt_next   = '0;
                    if (s_tuser == KIND_CLEAR)
                    begin
                        state_next = FSM_CLR;
                    end
                    else
                    begin
                        state_next = FSM_B;
                    end
                end
            end
            FSM_B:
            begin
                meta_next      = meta_rd;
                nxt_next       = next_rd;
                hd_next        = bin_rd.head;
                bin_req.raddr  = meta_rd.bin;
                state_next     = FSM_FIN;
                case (kind_reg)
                    KIND_MOVE:
                    begin
                        if (meta_rd.vld && meta_rd.bin == bin_reg)
                        begin
                            res_next.status = ST_NOTHING;
                        end
                        else if (meta_rd.vld && meta_rd.tag != ver_reg)
                        begin
                            res_next.status = ST_MISMATCH;
                        end
                        else
                        begin
                            upd_next   = 1'b1;
                            state_next = FSM_C;
                        end
                    end
                    KIND_REMOVE:
                    begin
                        if (!meta_rd.vld)
                        begin
                            res_next.status = ST_NOTHING;
                        end
                        else if (meta_rd.tag != ver_reg)
                        begin
                            res_next.status = ST_MISMATCH;
                        end
                        else
                        begin
                            upd_next   = 1'b1;
                            state_next = FSM_C;
                        end
                    end
                    KIND_BINQ:
                    begin
                        meta_req.raddr      = bin_rd.head.idx;
                        res_next.count      = bin_rd.cnt;
                        res_next.link_valid = bin_rd.head.vld;
                        res_next.link_index = bin_rd.head.vld ? bin_rd.head.idx : '0;
                        state_next          = FSM_C;
                    end
                    KIND_ENTQ:
                    begin
                        meta_req.raddr = next_rd.idx;
                        if (meta_rd.vld)
                        begin
                            res_next.status     = (meta_rd.tag != ver_reg) ? ST_MISMATCH
                                                                           : ST_DONE;
                            res_next.found      = 1'b1;
                            res_next.bin_out    = meta_rd.bin;
                            res_next.link_valid = next_rd.vld;
                            res_next.link_index = next_rd.vld ? next_rd.idx : '0;
                        end
                        state_next = FSM_C;
                    end
                    default:
                    begin
                        res_next.status = ST_NOTHING;
                    end
                endcase
                if (upd_next)
                begin
                    // bridge the neighbors around the entity
                    next_req.we    = prev_rd.vld && meta_rd.vld;
                    next_req.waddr = prev_rd.idx;
                    next_req.wdata = next_rd;
                    prev_req.we    = next_rd.vld && meta_rd.vld;
                    prev_req.waddr = next_rd.idx;
                    prev_req.wdata = prev_rd;
                    meta_req.we    = 1'b1;
                    meta_req.waddr = ent_reg;
                    if (kind_reg == KIND_MOVE)
                    begin
                        meta_req.wdata = '{vld: 1'b1, bin: bin_reg, tag: ver_reg};
                        bin_req.we     = 1'b1;
                        bin_req.waddr  = bin_reg;
                        bin_req.wdata.head = '{vld: 1'b1, idx: ent_reg};
                        bin_req.wdata.cnt  = bin_rd.cnt + 1'b1;
                    end
                end
            end
            FSM_C:
            begin
                state_next = FSM_FIN;
                if (upd_reg)
                begin
                    // retire the old bin, then seat the entity's own links
                    bin_req.we    = meta_reg.vld;
                    bin_req.waddr = meta_reg.bin;
                    bin_req.wdata.cnt = (bin_rd.cnt != '0) ? bin_rd.cnt - 1'b1 : '0;
                    bin_req.wdata.head = (bin_rd.head.vld && bin_rd.head.idx == ent_reg)
                                         ? nxt_reg : bin_rd.head;
                    next_req.we    = 1'b1;
                    next_req.waddr = ent_reg;
                    next_req.wdata = (kind_reg == KIND_MOVE) ? hd_reg : '0;
                    prev_req.we    = 1'b1;
                    prev_req.waddr = ent_reg;
                    prev_req.wdata = '0;
                    state_next     = FSM_D;
                end
                else if (res_reg.link_valid)
                begin
                    res_next.link_version = meta_rd.tag;
                end
            end
            FSM_D:
            begin
                prev_req.we    = (kind_reg == KIND_MOVE) && hd_reg.vld;
                prev_req.waddr = hd_reg.idx;
                prev_req.wdata = '{vld: 1'b1, idx: ent_reg};
                state_next     = FSM_FIN;
            end
            FSM_FIN:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    out_next   = res_reg;
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    assign out_valid = ov_reg;
    assign out_res   = out_reg;

endmodule

/* rtl/bin_membership_linked_lists_core.sv */
`timescale 1ns / 1ps
// Steps: an updating move or remove reads, unlinks and relinks; a query reads then looks
//   up the link version; clear sweeps one entity slot per cycle over 1024 slots.
// Throughput: one word at a time; the next word is taken once the result is staged,
//   set by the read-modify-write sequence over the single-port-pair memories.
// Reset: asynchronous, active low; after release a clearing pass over all 1024 entity
//   slots runs with s_tready low.
module bin_membership_linked_lists_core
    import blml_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // bin_index[5:0], entity_index[15:6], entity_version[31:16]
    input  logic [31:0] s_tdata,
    // kind[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // found[0], bin_out[6:1], count[17:7], link_valid[18], link_index[28:19],
    // link_version[44:29], zero fill[47:45]
    output logic [47:0] m_tdata,
    // status[1:0]
    output logic [1:0]  m_tuser
);

    meta_req_t meta_req;
    link_req_t prev_req;
    link_req_t next_req;
    bin_req_t  bin_req;
    meta_t     meta_rd;
    link_t     prev_rd;
    link_t     next_rd;
    bin_ent_t  bin_rd;
    res_t      res;

    // sequencer: walk each word through read, unlink, relink and result
    blml_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res),
        .meta_req  (meta_req),
        .meta_rd   (meta_rd),
        .prev_req  (prev_req),
        .prev_rd   (prev_rd),
        .next_req  (next_req),
        .next_rd   (next_rd),
        .bin_req   (bin_req),
        .bin_rd    (bin_rd)
    );

    // per-entity membership: binned flag, bin and stored version
    blml_ram #(.DEPTH(ENT_DEPTH), .WIDTH($bits(meta_t))) u_meta (
        .clk   (clk),
        .we    (meta_req.we),
        .waddr (meta_req.waddr),
        .wdata (meta_req.wdata),
        .raddr (meta_req.raddr),
        .rdata (meta_rd)
    );

    // backward links
    blml_ram #(.DEPTH(ENT_DEPTH), .WIDTH($bits(link_t))) u_prev (
        .clk   (clk),
        .we    (prev_req.we),
        .waddr (prev_req.waddr),
        .wdata (prev_req.wdata),
        .raddr (prev_req.raddr),
        .rdata (prev_rd)
    );

    // forward links
    blml_ram #(.DEPTH(ENT_DEPTH), .WIDTH($bits(link_t))) u_next (
        .clk   (clk),
        .we    (next_req.we),
        .waddr (next_req.waddr),
        .wdata (next_req.wdata),
        .raddr (next_req.raddr),
        .rdata (next_rd)
    );

    // per-bin head link and member count
    blml_ram #(.DEPTH(BIN_DEPTH), .WIDTH($bits(bin_ent_t))) u_bin (
        .clk   (clk),
        .we    (bin_req.we),
        .waddr (bin_req.waddr),
        .wdata (bin_req.wdata),
        .raddr (bin_req.raddr),
        .rdata (bin_rd)
    );

    assign m_tuser = res.status;
    assign m_tdata = {3'b000, res.link_version, res.link_index, res.link_valid,
                      res.count, res.bin_out, res.found};

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top
    import blml_pkg::*;
;

    localparam int NO_LINK  = -1;
    localparam int WD_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    // bin_index[5:0], entity_index[15:6], entity_version[31:16]
    logic [31:0] s_tdata;
    // kind[2:0]
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    // found[0], bin_out[6:1], count[17:7], link_valid[18], link_index[28:19],
    // link_version[44:29], zero fill[47:45]
    logic [47:0] m_tdata;
    // status[1:0]
    logic [1:0]  m_tuser;

    bin_membership_linked_lists_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Shadow copy of the list state; -1 stands for no link / not binned.
    int          head_of   [BIN_DEPTH];
    int          members_of[BIN_DEPTH];
    int          bin_of    [ENT_DEPTH];
    int          prev_of   [ENT_DEPTH];
    int          next_of   [ENT_DEPTH];
    logic [15:0] tag_of    [ENT_DEPTH];

    res_t expected_words[$];
    int   errors;
    int   results_seen;
    int   idle_send_pct;
    int   stall_recv_pct;
    int   wd_count;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void clear_lists();
        for (int i = 0; i < BIN_DEPTH; i++)
        begin
            head_of[i]    = NO_LINK;
            members_of[i] = 0;
        end
        for (int i = 0; i < ENT_DEPTH; i++)
        begin
            bin_of[i]  = NO_LINK;
            prev_of[i] = NO_LINK;
            next_of[i] = NO_LINK;
            tag_of[i]  = '0;
        end
    endfunction

    function automatic void unlink(int e);
        int b;
        int p;
        int n;
        b = bin_of[e];
        p = prev_of[e];
        n = next_of[e];
        if (b >= 0)
        begin
            if (members_of[b] > 0)
                members_of[b]--;
            if (head_of[b] == e)
                head_of[b] = n;
        end
        if (p >= 0)
            next_of[p] = n;
        if (n >= 0)
            prev_of[n] = p;
        bin_of[e]  = NO_LINK;
        prev_of[e] = NO_LINK;
        next_of[e] = NO_LINK;
        tag_of[e]  = '0;
    endfunction

    function automatic void put_link(ref res_t r, input int e);
        if (e >= 0)
        begin
            r.link_valid   = 1'b1;
            r.link_index   = e[ENT_W-1:0];
            r.link_version = tag_of[e];
        end
    endfunction

    // Apply one operation to the shadow lists and return the result word.
    function automatic res_t apply_bin_op(logic [2:0] kind, int b, int e, logic [15:0] ver);
        res_t r;
        int   old;
        r = '0;
        r.status = ST_DONE;
        case (kind)
            KIND_MOVE:
            begin
                if (bin_of[e] == b)
                    r.status = ST_NOTHING;
                else if (bin_of[e] >= 0 && tag_of[e] != ver)
                    r.status = ST_MISMATCH;
                else
                begin
                    if (bin_of[e] >= 0)
                        unlink(e);
                    old = head_of[b];
                    head_of[b] = e;
                    members_of[b]++;
                    bin_of[e]  = b;
                    tag_of[e]  = ver;
                    prev_of[e] = NO_LINK;
                    next_of[e] = old;
                    if (old >= 0)
                        prev_of[old] = e;
                end
            end
            KIND_REMOVE:
            begin
                if (bin_of[e] < 0)
                    r.status = ST_NOTHING;
                else if (tag_of[e] != ver)
                    r.status = ST_MISMATCH;
                else
                    unlink(e);
            end
            KIND_BINQ:
            begin
                r.count = members_of[b][CNT_W-1:0];
                put_link(r, head_of[b]);
            end
            KIND_ENTQ:
            begin
                if (bin_of[e] >= 0)
                begin
                    if (tag_of[e] != ver)
                        r.status = ST_MISMATCH;
                    r.found   = 1'b1;
                    r.bin_out = bin_of[e][BIN_W-1:0];
                    put_link(r, next_of[e]);
                end
            end
            KIND_CLEAR: clear_lists();
            default: r.status = ST_NOTHING;
        endcase
        return r;
    endfunction

    // Send one word and queue its expected result; drop tvalid only while idling.
    task automatic send_op(logic [2:0] kind, int b, int e, logic [15:0] ver);
        while ($urandom_range(99) < idle_send_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {ver, e[ENT_W-1:0], b[BIN_W-1:0]};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_words.push_back(apply_bin_op(kind, b, e, ver));
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Receiver: random stalls on tready, compare each word with the oldest expectation.
    always @(posedge clk)
    begin
        res_t got;
        res_t exp_w;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got              = '0;
                got.status       = status_t'(m_tuser);
                got.found        = m_tdata[0];
                got.bin_out      = m_tdata[6:1];
                got.count        = m_tdata[17:7];
                got.link_valid   = m_tdata[18];
                got.link_index   = m_tdata[28:19];
                got.link_version = m_tdata[44:29];
                results_seen++;
                if (expected_words.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, got);
                    errors++;
                end
                else
                begin
                    exp_w = expected_words.pop_front();
                    if (got !== exp_w || m_tdata[47:45] !== 3'b0)
                    begin
                        $display("%0t: mismatch expected %h actual %h (fill %b)",
                                 $time, exp_w, got, m_tdata[47:45]);
                        errors++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= stall_recv_pct);
        end
    end

    // Watchdog: count cycles with no accepted word on either side.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            wd_count <= 0;
        else
            wd_count <= wd_count + 1;
        if (wd_count >= WD_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic test_directed();
        send_op(KIND_BINQ, 0, 0, 16'h0);
        send_op(KIND_ENTQ, 0, 0, 16'h0);
        send_op(KIND_REMOVE, 0, 0, 16'h0);       // remove of unbinned entity
        send_op(KIND_MOVE, 0, 0, 16'h0000);
        send_op(KIND_MOVE, 0, 1023, 16'hFFFF);
        send_op(KIND_MOVE, 63, 5, 16'h1234);
        send_op(KIND_MOVE, 63, 5, 16'h9999);     // same bin, tag ignored
        send_op(KIND_MOVE, 0, 5, 16'h1111);      // wrong tag from another bin
        send_op(KIND_MOVE, 0, 5, 16'h1234);      // real move
        send_op(KIND_BINQ, 0, 0, 16'h0);
        send_op(KIND_BINQ, 63, 0, 16'h0);
        send_op(KIND_ENTQ, 0, 5, 16'h1234);
        send_op(KIND_ENTQ, 0, 1023, 16'h0001);   // query with wrong tag
        send_op(KIND_ENTQ, 0, 0, 16'h0);         // tail of list
        send_op(KIND_REMOVE, 0, 1023, 16'h0);    // remove with wrong tag
        send_op(KIND_REMOVE, 0, 1023, 16'hFFFF);
        send_op(KIND_REMOVE, 0, 5, 16'h1234);    // remove the head
        send_op(3'd5, 0, 0, 16'h0);
        send_op(3'd6, 63, 1023, 16'hFFFF);
        send_op(3'd7, 1, 2, 16'h3);
        send_op(KIND_CLEAR, 0, 0, 16'h0);
        send_op(KIND_BINQ, 0, 0, 16'h0);
        send_op(KIND_ENTQ, 0, 0, 16'h0);
        wait_drain();
    endtask

    // Random phase: work on a small entity pool so lists grow long and tags hit.
    task automatic test_random(int n, int send_pct, int recv_pct);
        int          r;
        int          e;
        int          b;
        logic [2:0]  k;
        logic [15:0] v;
        idle_send_pct  = send_pct;
        stall_recv_pct = recv_pct;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            e = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(31);
            b = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(3);
            if (bin_of[e] >= 0 && $urandom_range(3) != 0)
                v = tag_of[e];
            else
                v = 16'($urandom);
            if (r < 40)      k = KIND_MOVE;
            else if (r < 60) k = KIND_REMOVE;
            else if (r < 75) k = KIND_BINQ;
            else if (r < 96) k = KIND_ENTQ;
            else if (r < 98) k = 3'($urandom_range(7, 5));
            else             k = KIND_CLEAR;
            send_op(k, b, e, v);
        end
        wait_drain();
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        m_tready = 1'b0;
        errors   = 0;
        results_seen   = 0;
        wd_count       = 0;
        idle_send_pct  = 0;
        stall_recv_pct = 0;
        clear_lists();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random(200, 0, 0);
        test_random(200, 83, 0);
        test_random(200, 0, 83);
        test_random(200, 13, 13);

        $display("Covered moves, removes, bin and entity queries, clears and unknown kinds,");
        $display("%0d results checked across four idle/stall phases.", results_seen);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
